// ===== sv/hpa_pkg.sv =====
package hpa_pkg;

    // field widths
    localparam int HEADING_W   = 12;
    localparam int CURRENT_W   = 10;
    localparam int TIME_W      = 32;
    localparam int DEADBAND_W  = 8;
    localparam int GAIN_W      = 24;
    localparam int ERR_W       = 13;
    localparam int DERR_W      = 14;
    localparam int CMD_W       = 8;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // derivative numerator: gain times |error change| times 1000
    localparam int SCALED_W    = 23;
    localparam int DERIV_NUM_W = 47;
    localparam int PROD_W      = 38;
    localparam int TOTAL_W     = 49;

    // control constants
    localparam int WRAP_LIMIT  = 1800;
    localparam int FULL_TURN   = 3600;
    localparam int MS_PER_S    = 1000;
    localparam int CMD_MAX     = 100;
    // 101 * 2560: smallest magnitude that saturates the command
    localparam int SAT_LIMIT   = 258560;
    // x * 205 >> 10 equals x / 5 for the narrow values used here
    localparam int RECIP5      = 205;
    localparam int DEADBAND_SCALE = 10;

    localparam int QUEUE_DEPTH = 2;

    // mode request codes
    localparam logic [1:0] MODE_KEEP    = 2'd0;
    localparam logic [1:0] MODE_ENGAGE  = 2'd1;
    localparam logic [1:0] MODE_STANDBY = 2'd2;

    // register indexes
    localparam logic [2:0] REG_BEARING   = 3'd0;
    localparam logic [2:0] REG_DEADBAND  = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;

    // register reset values
    localparam logic [HEADING_W-1:0]  RST_BEARING   = 12'd0;
    localparam logic [DEADBAND_W-1:0] RST_DEADBAND  = 8'd10;
    localparam logic [GAIN_W-1:0]     RST_PROP_GAIN = 24'd256000;
    localparam logic [GAIN_W-1:0]     RST_DERIV_GAIN = 24'd0;
    localparam logic [CURRENT_W-1:0]  RST_THRESHOLD = 10'd159;

    typedef struct packed {
        logic [HEADING_W-1:0] heading_now;
        logic [CURRENT_W-1:0] current_code;
        logic [TIME_W-1:0]    time_ms;
        logic [1:0]           mode_request;
        logic                 driver_ready;
    } in_t;

    typedef struct packed {
        logic                    command_valid;
        logic signed [CMD_W-1:0] tiller_command;
        logic                    overload;
        logic                    autopilot_on;
    } out_t;

    typedef struct packed {
        logic [HEADING_W-1:0]  target_bearing;
        logic [DEADBAND_W-1:0] deadband_degrees;
        logic [GAIN_W-1:0]     prop_gain;
        logic [GAIN_W-1:0]     deriv_gain;
        logic [CURRENT_W-1:0]  overload_threshold;
    } cfg_t;

    // what the back end has to do with a pass
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_PD   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     overload;
        logic                     autopilot_on;
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
        logic [TIME_W-1:0]        dt;
    } task_t;

endpackage

// ===== sv/heading_pd_autopilot_core.sv =====
// a word with no computed command goes from the queue to the output register once the
//   back end is idle and the output free; a computed command runs MUL1, MUL2, DIV, SUM,
//   ABS and DONE, the 47-step bit-serial divider being skipped when no time has elapsed
// throughput: other words one per cycle while the output is free; none during a command
// reset: synchronous, active low; standby mode, last error and time cleared,
//   registers to defaults, queue and output empty
module heading_pd_autopilot_core #(
    parameter int QUEUE_DEPTH = hpa_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  hpa_pkg::in_t                  s_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hpa_pkg::out_t                 m_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpa_pkg::ADDR_W-1:0]    paddr,
    input  logic [hpa_pkg::DATA_W-1:0]    pwdata,
    output logic [hpa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    hpa_pkg::cfg_t   cfg_reg, cfg_next;
    logic            cfg_wr;
    logic [2:0]      reg_idx;
    logic            q_full;
    logic            q_push;
    hpa_pkg::task_t  q_task;
    logic            q_pop;
    logic            q_valid;
    hpa_pkg::task_t  q_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                hpa_pkg::REG_BEARING:    cfg_next.target_bearing     = pwdata[11:0];
                hpa_pkg::REG_DEADBAND:   cfg_next.deadband_degrees   = pwdata[7:0];
                hpa_pkg::REG_PROP_GAIN:  cfg_next.prop_gain          = pwdata[23:0];
                hpa_pkg::REG_DERIV_GAIN: cfg_next.deriv_gain         = pwdata[23:0];
                hpa_pkg::REG_THRESHOLD:  cfg_next.overload_threshold = pwdata[9:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{target_bearing: hpa_pkg::RST_BEARING,
                         deadband_degrees: hpa_pkg::RST_DEADBAND,
                         prop_gain: hpa_pkg::RST_PROP_GAIN,
                         deriv_gain: hpa_pkg::RST_DERIV_GAIN,
                         overload_threshold: hpa_pkg::RST_THRESHOLD};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            hpa_pkg::REG_BEARING:    prdata = 32'(cfg_reg.target_bearing);
            hpa_pkg::REG_DEADBAND:   prdata = 32'(cfg_reg.deadband_degrees);
            hpa_pkg::REG_PROP_GAIN:  prdata = 32'(cfg_reg.prop_gain);
            hpa_pkg::REG_DERIV_GAIN: prdata = 32'(cfg_reg.deriv_gain);
            hpa_pkg::REG_THRESHOLD:  prdata = 32'(cfg_reg.overload_threshold);
            default:                 prdata = '0;
        endcase
    end

    hpa_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_task  (q_task)
    );

    hpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_task  (q_task),
        .full       (q_full),
        .pop        (q_pop),
        .task_valid (q_valid),
        .task_out   (q_head)
    );

    hpa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .task_valid (q_valid),
        .task_in    (q_head),
        .task_pop   (q_pop),
        .cfg        (cfg_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    // command stays within the saturation limits
    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_word.tiller_command <= 8'sd100) && (m_word.tiller_command >= -8'sd100))
        else $error("tiller command out of range");

    // a word without command_valid carries a zero drive value
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.command_valid |-> m_word.tiller_command == '0)
        else $error("non-zero command without command_valid");

    // an overload always issues a zero command and forces standby
    a_overload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.overload |->
            m_word.command_valid && !m_word.autopilot_on && m_word.tiller_command == '0)
        else $error("overload word inconsistent");

    // queue is never written while full
    a_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overrun");

endmodule

// ===== sv/hpa_front.sv =====
module hpa_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  hpa_pkg::in_t    s_word,
    input  hpa_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            q_push,
    output hpa_pkg::task_t  q_task
);

    localparam logic signed [hpa_pkg::ERR_W-1:0] TURN =
        hpa_pkg::ERR_W'(hpa_pkg::FULL_TURN);

    logic                                  mode_reg, mode_next;
    logic signed [hpa_pkg::ERR_W-1:0]      last_err_reg, last_err_next;
    logic [hpa_pkg::TIME_W-1:0]            last_time_reg, last_time_next;

    logic                                  mode_req_v;
    logic                                  over;
    logic                                  mode_after;
    logic                                  run;
    logic signed [hpa_pkg::ERR_W-1:0]      err_raw;
    logic signed [hpa_pkg::ERR_W-1:0]      err_neg;
    logic [hpa_pkg::HEADING_W-1:0]         err_mag;
    logic [10:0]                           half;
    logic                                  inband;
    logic                                  wide;
    logic signed [hpa_pkg::ERR_W-1:0]      err_w;
    logic signed [hpa_pkg::DERR_W-1:0]     derr;
    logic [hpa_pkg::TIME_W-1:0]            dt;
    hpa_pkg::kind_t                        kind;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // mode request
    always_comb begin
        case (s_word.mode_request)
            hpa_pkg::MODE_ENGAGE:  mode_req_v = 1'b1;
            hpa_pkg::MODE_STANDBY: mode_req_v = 1'b0;
            default:               mode_req_v = mode_reg;
        endcase
    end

    // overload trip forces standby
    assign over       = s_word.current_code > cfg.overload_threshold;
    assign mode_after = over ? 1'b0 : mode_req_v;
    assign run        = mode_after && s_word.driver_ready;

    // heading error and deadband
    assign err_raw = $signed({1'b0, s_word.heading_now}) - $signed({1'b0, cfg.target_bearing});
    assign err_neg = -err_raw;
    assign err_mag = err_raw[hpa_pkg::ERR_W-1] ? err_neg[hpa_pkg::HEADING_W-1:0]
                                               : err_raw[hpa_pkg::HEADING_W-1:0];
    assign half    = 11'(cfg.deadband_degrees[7:1]) * 11'(hpa_pkg::DEADBAND_SCALE);
    assign inband  = err_mag < 12'(half);
    assign wide    = err_mag > 12'(hpa_pkg::WRAP_LIMIT);

    // wrap past half a turn
    always_comb begin
        if (!wide) begin
            err_w = err_raw;
        end else if (cfg.target_bearing > s_word.heading_now) begin
            err_w = err_raw + TURN;
        end else begin
            err_w = err_raw - TURN;
        end
    end

    assign derr = {err_w[hpa_pkg::ERR_W-1], err_w}
                - {last_err_reg[hpa_pkg::ERR_W-1], last_err_reg};
    assign dt   = s_word.time_ms - last_time_reg;

    // classify the pass
    always_comb begin
        if (run && !inband) begin
            kind = hpa_pkg::KIND_PD;
        end else if (run || over) begin
            kind = hpa_pkg::KIND_ZERO;
        end else begin
            kind = hpa_pkg::KIND_NONE;
        end
    end

    assign q_task = '{kind: kind, overload: over, autopilot_on: mode_after,
                      err: err_w, derr: derr, dt: dt};

    // loop state update
    always_comb begin
        mode_next      = mode_reg;
        last_err_next  = last_err_reg;
        last_time_next = last_time_reg;
        if (q_push) begin
            mode_next = mode_after;
            if (kind == hpa_pkg::KIND_PD) begin
                last_err_next  = err_w;
                last_time_next = s_word.time_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            last_err_reg  <= '0;
            last_time_reg <= '0;
        end else begin
            mode_reg      <= mode_next;
            last_err_reg  <= last_err_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// ===== sv/hpa_queue.sv =====
module hpa_queue #(
    parameter int DEPTH = hpa_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  hpa_pkg::task_t  push_task,
    output logic            full,
    input  logic            pop,
    output logic            task_valid,
    output hpa_pkg::task_t  task_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hpa_pkg::task_t      mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign task_valid = count_reg != '0;
    assign task_out   = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

// ===== sv/hpa_back.sv =====
module hpa_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            task_valid,
    input  hpa_pkg::task_t  task_in,
    output logic            task_pop,
    input  hpa_pkg::cfg_t   cfg,
    output logic            m_valid,
    input  logic            m_ready,
    output hpa_pkg::out_t   m_word
);

    localparam int NUM_W = hpa_pkg::DERIV_NUM_W;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL1 = 7'b0000010,
        ST_MUL2 = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_ABS  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t                                 state_reg, state_next;
    logic signed [hpa_pkg::ERR_W-1:0]       err_reg, err_next;
    logic [hpa_pkg::DERR_W-1:0]             dmag_reg, dmag_next;
    logic                                   dneg_reg, dneg_next;
    logic [hpa_pkg::TIME_W-1:0]             dt_reg, dt_next;
    logic                                   ap_reg, ap_next;
    logic signed [hpa_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [hpa_pkg::SCALED_W-1:0]           scaled_reg, scaled_next;
    logic [NUM_W-1:0]                       num_reg, num_next;
    logic [hpa_pkg::TIME_W-1:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]                       cnt_reg, cnt_next;
    logic signed [hpa_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic [hpa_pkg::TOTAL_W-2:0]            mag_reg, mag_next;
    logic                                   neg_reg, neg_next;
    logic                                   m_valid_reg, m_valid_next;
    hpa_pkg::out_t                          m_word_reg, m_word_next;

    logic                                   out_free;
    logic signed [hpa_pkg::DERR_W-1:0]      derr_neg;
    logic [hpa_pkg::TIME_W:0]               rem_sh;
    logic [hpa_pkg::TIME_W:0]               rem_diff;
    logic                                   q_bit;
    logic signed [hpa_pkg::TOTAL_W-1:0]     deriv;
    logic signed [hpa_pkg::TOTAL_W-1:0]     total_neg;
    logic                                   sat;
    logic [16:0]                            recip;
    logic [6:0]                             cmd_mag;
    logic [hpa_pkg::CMD_W-1:0]              cmd_pos;
    logic [hpa_pkg::CMD_W-1:0]              cmd;

    assign out_free = !m_valid_reg || m_ready;
    assign derr_neg = -task_in.derr;

    // one restoring divide step
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, dt_reg};
    assign q_bit    = rem_sh >= {1'b0, dt_reg};

    // sum of proportional and derivative terms
    assign deriv     = $signed({2'b00, num_reg});
    assign total_neg = -total_reg;

    // divide by 2560 and saturate
    assign sat     = mag_reg >= (hpa_pkg::TOTAL_W-1)'(hpa_pkg::SAT_LIMIT);
    assign recip   = 17'(mag_reg[17:9]) * 17'(hpa_pkg::RECIP5);
    assign cmd_mag = sat ? 7'(hpa_pkg::CMD_MAX) : recip[16:10];
    assign cmd_pos = {1'b0, cmd_mag};
    assign cmd     = neg_reg ? -cmd_pos : cmd_pos;

    always_comb begin
        state_next   = state_reg;
        err_next     = err_reg;
        dmag_next    = dmag_reg;
        dneg_next    = dneg_reg;
        dt_next      = dt_reg;
        ap_next      = ap_reg;
        prod_next    = prod_reg;
        scaled_next  = scaled_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        task_pop     = 1'b0;

        case (state_reg)
            // take the next word from the queue
            ST_IDLE: begin
                if (task_valid) begin
                    if (task_in.kind == hpa_pkg::KIND_PD) begin
                        task_pop   = 1'b1;
                        err_next   = task_in.err;
                        dneg_next  = task_in.derr[hpa_pkg::DERR_W-1];
                        dmag_next  = task_in.derr[hpa_pkg::DERR_W-1] ? derr_neg : task_in.derr;
                        dt_next    = task_in.dt;
                        ap_next    = task_in.autopilot_on;
                        state_next = ST_MUL1;
                    end else if (out_free) begin
                        task_pop     = 1'b1;
                        m_valid_next = 1'b1;
                        m_word_next  = '{command_valid: task_in.kind == hpa_pkg::KIND_ZERO,
                                         tiller_command: '0,
                                         overload: task_in.overload,
                                         autopilot_on: task_in.autopilot_on};
                    end
                end
            end
            // proportional product and error change in per-second units
            ST_MUL1: begin
                prod_next   = hpa_pkg::PROD_W'($signed({1'b0, cfg.prop_gain}))
                            * hpa_pkg::PROD_W'(err_reg);
                scaled_next = hpa_pkg::SCALED_W'(dmag_reg)
                            * hpa_pkg::SCALED_W'(hpa_pkg::MS_PER_S);
                state_next  = ST_MUL2;
            end
            // derivative numerator, skip the divide on zero elapsed time
            ST_MUL2: begin
                rem_next = '0;
                cnt_next = '0;
                if (dt_reg == '0) begin
                    num_next   = '0;
                    state_next = ST_SUM;
                end else begin
                    num_next   = NUM_W'(cfg.deriv_gain) * NUM_W'(scaled_reg);
                    state_next = ST_DIV;
                end
            end
            // one quotient bit a cycle, shifted into the numerator register
            ST_DIV: begin
                rem_next = q_bit ? rem_diff[hpa_pkg::TIME_W-1:0] : rem_sh[hpa_pkg::TIME_W-1:0];
                num_next = {num_reg[NUM_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                total_next = hpa_pkg::TOTAL_W'(prod_reg) + (dneg_reg ? -deriv : deriv);
                state_next = ST_ABS;
            end
            ST_ABS: begin
                neg_next   = total_reg[hpa_pkg::TOTAL_W-1];
                mag_next   = total_reg[hpa_pkg::TOTAL_W-1] ? total_neg[hpa_pkg::TOTAL_W-2:0]
                                                           : total_reg[hpa_pkg::TOTAL_W-2:0];
                state_next = ST_DONE;
            end
            // hand the command to the output register
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = '{command_valid: 1'b1, tiller_command: cmd,
                                     overload: 1'b0, autopilot_on: ap_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        dt_reg     <= dt_next;
        ap_reg     <= ap_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        total_reg  <= total_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== dv/heading_pd_autopilot_core_test.sv =====
module heading_pd_autopilot_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // reserved mode request, behaves as no change
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam longint CMD_DIVISOR    = 2560;
    localparam int     PHASES         = 8;
    localparam int     PHASE_PASSES   = 210;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     TAIL_CYCLES    = 80;

    typedef struct {
        bit             is_write;
        logic [2:0]     reg_idx;
        logic [31:0]    reg_val;
        hpa_pkg::in_t   word;
        bit             typed;
        hpa_pkg::out_t  want;
    } plan_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    hpa_pkg::in_t                 s_word;
    logic                         m_valid;
    logic                         m_ready;
    hpa_pkg::out_t                m_word;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [hpa_pkg::ADDR_W-1:0]   paddr;
    logic [hpa_pkg::DATA_W-1:0]   pwdata;
    logic [hpa_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // register shadow
    logic [hpa_pkg::HEADING_W-1:0]  cfg_bearing;
    logic [hpa_pkg::DEADBAND_W-1:0] cfg_deadband;
    logic [hpa_pkg::GAIN_W-1:0]     cfg_kp;
    logic [hpa_pkg::GAIN_W-1:0]     cfg_kd;
    logic [hpa_pkg::CURRENT_W-1:0]  cfg_threshold;

    // controller state as predicted
    bit          ap_mode;
    int          prev_err;
    logic [31:0] prev_time;

    hpa_pkg::out_t pending_cmds[$];
    plan_row_t     plan[$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   rx_hold = 0;
    bit            quiet = 1'b0;
    logic [31:0]   stim_time = '0;
    hpa_pkg::out_t want_now;

    heading_pd_autopilot_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // one control pass: mode request, overload trip, then the pd law
    function automatic hpa_pkg::out_t predict_pass(hpa_pkg::in_t w);
        hpa_pkg::out_t r;
        int            heading;
        int            bearing;
        int            err;
        int            mag;
        int            half;
        int            derr;
        logic [31:0]   dt;
        longint        deriv;
        longint        cmd;
        r = '0;
        if (w.mode_request == hpa_pkg::MODE_ENGAGE) begin
            ap_mode = 1'b1;
        end else if (w.mode_request == hpa_pkg::MODE_STANDBY) begin
            ap_mode = 1'b0;
        end
        if (w.current_code > cfg_threshold) begin
            r.overload = 1'b1;
            r.command_valid = 1'b1;
            ap_mode = 1'b0;
        end
        if (ap_mode && w.driver_ready) begin
            r.command_valid = 1'b1;
            heading = int'(w.heading_now);
            bearing = int'(cfg_bearing);
            err = heading - bearing;
            mag = (err < 0) ? -err : err;
            half = int'(cfg_deadband / 2) * hpa_pkg::DEADBAND_SCALE;
            if (mag >= half) begin
                // wrap past half a turn
                if (mag > hpa_pkg::WRAP_LIMIT) begin
                    if (bearing > heading) begin
                        err = err + hpa_pkg::FULL_TURN;
                    end else begin
                        err = err - hpa_pkg::FULL_TURN;
                    end
                end
                dt = w.time_ms - prev_time;
                derr = err - prev_err;
                prev_time = w.time_ms;
                prev_err = err;
                deriv = 0;
                if (dt != 0) begin
                    deriv = (longint'(cfg_kd) * longint'(derr) * hpa_pkg::MS_PER_S)
                          / longint'(dt);
                end
                cmd = (longint'(cfg_kp) * longint'(err) + deriv) / CMD_DIVISOR;
                if (cmd > hpa_pkg::CMD_MAX) begin
                    cmd = hpa_pkg::CMD_MAX;
                end
                if (cmd < -hpa_pkg::CMD_MAX) begin
                    cmd = -hpa_pkg::CMD_MAX;
                end
                r.tiller_command = 8'(cmd);
            end
        end
        r.autopilot_on = ap_mode;
        return r;
    endfunction

    function automatic hpa_pkg::out_t make_res(bit v, int cmd, bit ov, bit ap);
        hpa_pkg::out_t r;
        r.command_valid = v;
        r.tiller_command = 8'(cmd);
        r.overload = ov;
        r.autopilot_on = ap;
        return r;
    endfunction

    function automatic void add_pass(int h, int c, logic [31:0] t, logic [1:0] m, bit rdy,
                                     bit typed, hpa_pkg::out_t want);
        plan_row_t row;
        row = '{default: '0};
        row.word.heading_now = hpa_pkg::HEADING_W'(h);
        row.word.current_code = hpa_pkg::CURRENT_W'(c);
        row.word.time_ms = t;
        row.word.mode_request = m;
        row.word.driver_ready = rdy;
        row.typed = typed;
        row.want = want;
        plan.push_back(row);
    endfunction

    function automatic void add_write(logic [2:0] idx, logic [31:0] val);
        plan_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    // random pass, often engaged and near the bearing so the pd law is exercised
    function automatic hpa_pkg::in_t random_pass();
        hpa_pkg::in_t w;
        int unsigned  pick;
        int           off;
        int           half;
        int           base;
        logic [31:0]  step;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            w.mode_request = hpa_pkg::MODE_KEEP;
        end else if (pick < 85) begin
            w.mode_request = hpa_pkg::MODE_ENGAGE;
        end else if (pick < 93) begin
            w.mode_request = hpa_pkg::MODE_STANDBY;
        end else begin
            w.mode_request = MODE_RSVD;
        end
        w.driver_ready = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 92) begin
            w.current_code = hpa_pkg::CURRENT_W'($urandom_range(0, int'(cfg_threshold)));
        end else begin
            w.current_code = hpa_pkg::CURRENT_W'($urandom_range(0, 1023));
        end
        base = int'(cfg_bearing);
        half = int'(cfg_deadband / 2) * hpa_pkg::DEADBAND_SCALE;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            off = int'($urandom_range(0, 600)) - 300;
            w.heading_now = hpa_pkg::HEADING_W'(base + off);
        end else if (pick < 75) begin
            w.heading_now = hpa_pkg::HEADING_W'($urandom_range(0, 3599));
        end else if (pick < 85) begin
            w.heading_now = hpa_pkg::HEADING_W'($urandom_range(0, 4095));
        end else begin
            // deadband edges, wrap edges and field extremes
            case ($urandom_range(0, 7))
                0: off = half;
                1: off = half - 1;
                2: off = hpa_pkg::WRAP_LIMIT;
                3: off = hpa_pkg::WRAP_LIMIT + 1;
                4: off = hpa_pkg::WRAP_LIMIT - 1;
                default: off = 0;
            endcase
            if ($urandom_range(0, 1) != 0) begin
                off = -off;
            end
            case ($urandom_range(0, 4))
                0: w.heading_now = '0;
                1: w.heading_now = hpa_pkg::HEADING_W'(3599);
                2: w.heading_now = '1;
                default: w.heading_now = hpa_pkg::HEADING_W'(base + off);
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            step = '0;
        end else if (pick < 70) begin
            step = $urandom_range(1, 50);
        end else if (pick < 90) begin
            step = $urandom_range(1, 2000);
        end else begin
            step = $urandom;
        end
        stim_time = stim_time + step;
        w.time_ms = stim_time;
        return w;
    endfunction

    task automatic send_pass(input hpa_pkg::in_t w, input bit typed, input hpa_pkg::out_t want);
        int unsigned   gap;
        hpa_pkg::out_t p;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (!s_ready);
        p = predict_pass(w);
        pending_cmds.push_back(typed ? want : p);
    endtask

    // hold off the sender until every expected word is back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
    endtask

    // apb write, then read back the same register
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want;
        want = '0;
        case (idx)
            hpa_pkg::REG_BEARING: begin
                cfg_bearing = value[hpa_pkg::HEADING_W-1:0];
                want[hpa_pkg::HEADING_W-1:0] = cfg_bearing;
            end
            hpa_pkg::REG_DEADBAND: begin
                cfg_deadband = value[hpa_pkg::DEADBAND_W-1:0];
                want[hpa_pkg::DEADBAND_W-1:0] = cfg_deadband;
            end
            hpa_pkg::REG_PROP_GAIN: begin
                cfg_kp = value[hpa_pkg::GAIN_W-1:0];
                want[hpa_pkg::GAIN_W-1:0] = cfg_kp;
            end
            hpa_pkg::REG_DERIV_GAIN: begin
                cfg_kd = value[hpa_pkg::GAIN_W-1:0];
                want[hpa_pkg::GAIN_W-1:0] = cfg_kd;
            end
            hpa_pkg::REG_THRESHOLD: begin
                cfg_threshold = value[hpa_pkg::CURRENT_W-1:0];
                want[hpa_pkg::CURRENT_W-1:0] = cfg_threshold;
            end
            default: begin
            end
        endcase
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d read back expected %0h, got %0h",
                     $time, idx, want, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver stalls drawn per word
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            rx_hold = quiet ? 0 : $urandom_range(0, 3);
        end
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words outstanding",
                     $time, pending_cmds.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result word, got valid %0b cmd %0d ovl %0b ap %0b",
                         $time, m_word.command_valid, m_word.tiller_command,
                         m_word.overload, m_word.autopilot_on);
                mismatch_count++;
            end else begin
                want_now = pending_cmds.pop_front();
                if (m_word.command_valid !== want_now.command_valid) begin
                    $display("%0t: command_valid expected %0b, got %0b",
                             $time, want_now.command_valid, m_word.command_valid);
                    mismatch_count++;
                end
                if (m_word.tiller_command !== want_now.tiller_command) begin
                    $display("%0t: tiller_command expected %0d, got %0d",
                             $time, want_now.tiller_command, m_word.tiller_command);
                    mismatch_count++;
                end
                if (m_word.overload !== want_now.overload) begin
                    $display("%0t: overload expected %0b, got %0b",
                             $time, want_now.overload, m_word.overload);
                    mismatch_count++;
                end
                if (m_word.autopilot_on !== want_now.autopilot_on) begin
                    $display("%0t: autopilot_on expected %0b, got %0b",
                             $time, want_now.autopilot_on, m_word.autopilot_on);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned p;
        int unsigned n;
        plan_row_t   row;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cfg_bearing = hpa_pkg::RST_BEARING;
        cfg_deadband = hpa_pkg::RST_DEADBAND;
        cfg_kp = hpa_pkg::RST_PROP_GAIN;
        cfg_kd = hpa_pkg::RST_DERIV_GAIN;
        cfg_threshold = hpa_pkg::RST_THRESHOLD;
        ap_mode = 1'b0;
        prev_err = 0;
        prev_time = '0;

        // directed passes, default registers: deadband half is 50 tenths
        add_pass(0, 0, 0, hpa_pkg::MODE_KEEP, 1, 1, make_res(0, 0, 0, 0));
        add_pass(0, 0, 0, MODE_RSVD, 1, 1, make_res(0, 0, 0, 0));
        add_pass(0, 0, 0, hpa_pkg::MODE_ENGAGE, 0, 1, make_res(0, 0, 0, 1));
        add_pass(0, 0, 10, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, 0, 0, 1));
        add_pass(49, 0, 20, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, 0, 0, 1));
        add_pass(50, 0, 30, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, 100, 0, 1));
        add_pass(2700, 0, 40, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, -100, 0, 1));
        add_pass(1801, 0, 50, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, -100, 0, 1));
        add_pass(1800, 0, 60, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, 100, 0, 1));
        add_pass(4095, 0, 70, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, 100, 0, 1));
        // overload trips to standby
        add_pass(100, 160, 75, hpa_pkg::MODE_KEEP, 1, 1, make_res(1, 0, 1, 0));
        add_pass(3599, 159, 80, hpa_pkg::MODE_ENGAGE, 1, 1, make_res(1, -100, 0, 1));
        add_pass(100, 1023, 85, hpa_pkg::MODE_ENGAGE, 1, 1, make_res(1, 0, 1, 0));
        add_pass(0, 0, 90, hpa_pkg::MODE_ENGAGE, 1, 1, make_res(1, 0, 0, 1));
        add_pass(0, 0, 95, hpa_pkg::MODE_STANDBY, 1, 1, make_res(0, 0, 0, 0));
        // derivative term, zero elapsed time and timestamp wrap
        add_write(hpa_pkg::REG_DERIV_GAIN, 32'd256);
        add_write(hpa_pkg::REG_PROP_GAIN, 32'd256);
        add_pass(100, 0, 100, hpa_pkg::MODE_ENGAGE, 1, 0, '0);
        add_pass(100, 0, 100, hpa_pkg::MODE_KEEP, 1, 0, '0);
        add_pass(60, 0, 150, hpa_pkg::MODE_KEEP, 1, 0, '0);
        add_pass(3000, 0, 32'hFFFF_FFF0, hpa_pkg::MODE_KEEP, 1, 0, '0);
        add_pass(3100, 0, 32'd5, hpa_pkg::MODE_KEEP, 1, 0, '0);
        add_write(hpa_pkg::REG_BEARING, 32'd3599);
        add_pass(0, 0, 20, hpa_pkg::MODE_KEEP, 1, 0, '0);
        add_write(hpa_pkg::REG_THRESHOLD, 32'd1023);
        add_pass(3400, 1023, 40, hpa_pkg::MODE_KEEP, 1, 0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                drain();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_pass(row.word, row.typed, row.want);
            end
        end

        // random phases, each with its own register setting
        for (p = 0; p < PHASES; p++) begin
            drain();
            quiet = (p % 3 == 1);
            case (p)
                1: begin
                    write_reg(hpa_pkg::REG_BEARING, 32'd0);
                    write_reg(hpa_pkg::REG_DEADBAND, 32'd0);
                    write_reg(hpa_pkg::REG_PROP_GAIN, 32'hFF_FFFF);
                    write_reg(hpa_pkg::REG_DERIV_GAIN, 32'hFF_FFFF);
                    write_reg(hpa_pkg::REG_THRESHOLD, 32'd1023);
                end
                2: begin
                    write_reg(hpa_pkg::REG_BEARING, 32'd3599);
                    write_reg(hpa_pkg::REG_DEADBAND, 32'd180);
                    write_reg(hpa_pkg::REG_PROP_GAIN, 32'd0);
                    write_reg(hpa_pkg::REG_DERIV_GAIN, 32'd0);
                    write_reg(hpa_pkg::REG_THRESHOLD, 32'd0);
                end
                3: begin
                    write_reg(hpa_pkg::REG_BEARING, 32'hFFFF_FFFF);
                    write_reg(hpa_pkg::REG_DEADBAND, 32'hFFFF_FFFF);
                    write_reg(hpa_pkg::REG_PROP_GAIN, 32'd1);
                    write_reg(hpa_pkg::REG_DERIV_GAIN, 32'd1);
                    write_reg(hpa_pkg::REG_THRESHOLD, 32'd159);
                end
                default: begin
                    write_reg(hpa_pkg::REG_BEARING, $urandom_range(0, 3599));
                    write_reg(hpa_pkg::REG_DEADBAND, $urandom_range(0, 20));
                    write_reg(hpa_pkg::REG_PROP_GAIN, $urandom_range(16, 2048));
                    write_reg(hpa_pkg::REG_DERIV_GAIN, $urandom_range(0, 1024));
                    write_reg(hpa_pkg::REG_THRESHOLD, $urandom_range(600, 1000));
                end
            endcase
            for (n = 0; n < PHASE_PASSES; n++) begin
                // mid-phase pause until the pipe is empty
                if (n == PHASE_PASSES / 2) begin
                    drain();
                end
                send_pass(random_pass(), 0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
